@@ hdl/cspd_pkg.sv @@
package cspd_pkg;

  // Default width of the tick counters.
  localparam int COUNTER_WIDTH = 8;

  // Configuration port geometry.
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 3;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_STEP         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLAP_MIN_GAP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLAP_WINDOW       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_UNIT_TICKS = 3'd4;

  // Reset values of the registers and of the duty reference.
  localparam logic [CFG_W-1:0] RST_PWM_PERIOD        = 8'd50;
  localparam logic [CFG_W-1:0] RST_DUTY_STEP         = 8'd10;
  localparam logic [CFG_W-1:0] RST_CLAP_MIN_GAP      = 8'd25;
  localparam logic [CFG_W-1:0] RST_CLAP_WINDOW       = 8'd25;
  localparam logic [CFG_W-1:0] RST_WINDOW_UNIT_TICKS = 8'd100;
  localparam logic [CFG_W-1:0] RST_DUTY_REFERENCE    = 8'd50;

  // A clap sequence completes on this many valid claps.
  localparam logic [1:0] CLAPS_TO_TOGGLE = 2'd2;

  typedef struct packed {
    logic [CFG_W-1:0] pwm_period;
    logic [CFG_W-1:0] duty_step;
    logic [CFG_W-1:0] clap_min_gap;
    logic [CFG_W-1:0] clap_window;
    logic [CFG_W-1:0] window_unit_ticks;
  } cfg_t;

  typedef struct packed {
    logic tick;
    logic toggle_button;
    logic dim_button;
    logic clap;
  } step_in_t;

  typedef struct packed {
    logic             lamp;
    logic             lamp_enabled;
    logic [CFG_W-1:0] duty_level;
  } step_out_t;

endpackage

@@ hdl/cspd_in_if.sv @@
interface cspd_in_if;
  logic valid;
  logic ready;
  logic tick;
  logic toggle_button;
  logic dim_button;
  logic clap;

  modport source (output valid, output tick, output toggle_button, output dim_button,
                  output clap, input ready);
  modport sink (input valid, input tick, input toggle_button, input dim_button,
                input clap, output ready);
endinterface

@@ hdl/cspd_out_if.sv @@
interface cspd_out_if;
  logic       valid;
  logic       ready;
  logic       lamp;
  logic       lamp_enabled;
  logic [7:0] duty_level;

  modport source (output valid, output lamp, output lamp_enabled, output duty_level,
                  input ready);
  modport sink (input valid, input lamp, input lamp_enabled, input duty_level,
                output ready);
endinterface

@@ hdl/cspd_cfg_regs.sv @@
module cspd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [cspd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [cspd_pkg::CFG_W-1:0]     cfg_wdata,
  output cspd_pkg::cfg_t                 cfg
);

  cspd_pkg::cfg_t cfg_r;

  // Register file; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pwm_period        <= cspd_pkg::RST_PWM_PERIOD;
      cfg_r.duty_step         <= cspd_pkg::RST_DUTY_STEP;
      cfg_r.clap_min_gap      <= cspd_pkg::RST_CLAP_MIN_GAP;
      cfg_r.clap_window       <= cspd_pkg::RST_CLAP_WINDOW;
      cfg_r.window_unit_ticks <= cspd_pkg::RST_WINDOW_UNIT_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        cspd_pkg::REG_PWM_PERIOD:        cfg_r.pwm_period        <= cfg_wdata;
        cspd_pkg::REG_DUTY_STEP:         cfg_r.duty_step         <= cfg_wdata;
        cspd_pkg::REG_CLAP_MIN_GAP:      cfg_r.clap_min_gap      <= cfg_wdata;
        cspd_pkg::REG_CLAP_WINDOW:       cfg_r.clap_window       <= cfg_wdata;
        cspd_pkg::REG_WINDOW_UNIT_TICKS: cfg_r.window_unit_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hdl/cspd_step.sv @@
module cspd_step #(
  parameter int COUNTER_WIDTH = cspd_pkg::COUNTER_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  cspd_pkg::step_in_t  step_in,
  input  cspd_pkg::cfg_t      cfg,
  output cspd_pkg::step_out_t step_out
);

  localparam int CW    = COUNTER_WIDTH;
  localparam int CMP_W = (CW > cspd_pkg::CFG_W) ? CW : cspd_pkg::CFG_W;
  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  // Controller state.
  logic                      lamp_r,     lamp_nxt;
  logic                      en_r,       en_nxt;
  logic [CW-1:0]             sub_r,      sub_nxt;
  logic [CW-1:0]             win_r,      win_nxt;
  logic [CW-1:0]             gap_r,      gap_nxt;
  logic [CW-1:0]             pwm_r,      pwm_nxt;
  logic [1:0]                claps_r,    claps_nxt;
  logic [cspd_pkg::CFG_W-1:0] duty_r,    duty_nxt;
  logic                      tlatch_r,   tlatch_nxt;
  logic                      dlatch_r,   dlatch_nxt;

  // One full polling step, rules applied in order.
  always_comb begin
    lamp_nxt   = lamp_r;
    en_nxt     = en_r;
    sub_nxt    = sub_r;
    win_nxt    = win_r;
    gap_nxt    = gap_r;
    pwm_nxt    = pwm_r;
    claps_nxt  = claps_r;
    duty_nxt   = duty_r;
    tlatch_nxt = tlatch_r;
    dlatch_nxt = dlatch_r;

    // Tick counters.
    if (step_in.tick) begin
      sub_nxt = sub_r + CNT_ONE;
      gap_nxt = gap_r + CNT_ONE;
      if (en_r) begin
        pwm_nxt = pwm_r + CNT_ONE;
      end
    end

    // Toggle button, active low with a press latch.
    if (!step_in.toggle_button) begin
      if (!tlatch_r) begin
        lamp_nxt   = !lamp_r;
        tlatch_nxt = 1'b1;
        if (lamp_nxt) begin
          pwm_nxt = '0;
          en_nxt  = 1'b1;
        end else begin
          en_nxt = 1'b0;
        end
      end
    end else begin
      tlatch_nxt = 1'b0;
    end

    // Window unit rollover.
    if (CMP_W'(sub_nxt) == CMP_W'(cfg.window_unit_ticks)) begin
      sub_nxt = '0;
      win_nxt = win_r + CNT_ONE;
    end

    // Clap sequence.
    if (step_in.clap) begin
      if (CMP_W'(gap_nxt) >= CMP_W'(cfg.clap_min_gap) &&
          CMP_W'(win_nxt) <= CMP_W'(cfg.clap_window)) begin
        claps_nxt = claps_r + 2'd1;
        gap_nxt   = '0;
      end else begin
        win_nxt   = '0;
        gap_nxt   = '0;
        claps_nxt = '0;
      end
    end
    if (claps_nxt == cspd_pkg::CLAPS_TO_TOGGLE) begin
      lamp_nxt  = !lamp_nxt;
      en_nxt    = lamp_nxt;
      claps_nxt = '0;
    end

    // Dim button, active low with a press latch.
    if (!step_in.dim_button && !dlatch_r) begin
      if (duty_r > cfg.duty_step) begin
        duty_nxt = duty_r - cfg.duty_step;
      end else begin
        duty_nxt = cfg.pwm_period;
      end
      dlatch_nxt = 1'b1;
    end else if (step_in.dim_button && dlatch_r) begin
      dlatch_nxt = 1'b0;
    end

    // PWM drive against the duty reference.
    if (en_nxt) begin
      if (CMP_W'(pwm_nxt) >= CMP_W'(cfg.pwm_period)) begin
        pwm_nxt  = '0;
        lamp_nxt = 1'b1;
      end else if (CMP_W'(pwm_nxt) > CMP_W'(duty_nxt)) begin
        lamp_nxt = 1'b0;
      end else begin
        lamp_nxt = 1'b1;
      end
    end
  end

  // State advances once per transferred step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lamp_r   <= 1'b0;
      en_r     <= 1'b0;
      sub_r    <= '0;
      win_r    <= '0;
      gap_r    <= '0;
      pwm_r    <= '0;
      claps_r  <= '0;
      duty_r   <= cspd_pkg::RST_DUTY_REFERENCE;
      tlatch_r <= 1'b0;
      dlatch_r <= 1'b0;
    end else if (step_en) begin
      lamp_r   <= lamp_nxt;
      en_r     <= en_nxt;
      sub_r    <= sub_nxt;
      win_r    <= win_nxt;
      gap_r    <= gap_nxt;
      pwm_r    <= pwm_nxt;
      claps_r  <= claps_nxt;
      duty_r   <= duty_nxt;
      tlatch_r <= tlatch_nxt;
      dlatch_r <= dlatch_nxt;
    end
  end

  assign step_out.lamp         = lamp_nxt;
  assign step_out.lamp_enabled = en_nxt;
  assign step_out.duty_level   = duty_nxt;

endmodule

@@ hdl/clap_switch_pwm_dimmer_top.sv @@
// Clap-switch PWM lamp dimmer, one polling step per input transfer.
//
// Input channel (in_if): one transfer per polling pass carries tick,
// toggle_button, dim_button (buttons active low) and clap. Result channel
// (out_if): exactly one transfer per input, carrying lamp, lamp_enabled and
// duty_level after that step, in input order. Configuration (cfg_*): a
// write to register cfg_idx with cfg_wdata on any edge where cfg_we is high;
// write only while no step is in flight. Indexes 5 and up are ignored.
//
// Pipeline: the input register takes the step at its transfer, and the step
// logic fills the result register once it is free, where the result waits
// for out_if.ready. Throughput is one step per cycle while the receiver does
// not stall; the only loop is the controller state, which is updated in the
// same cycle its step moves into the result register.
//
// Reset (rst_n low, synchronous) empties both stages, clears the lamp and
// counters, loads the duty reference with 50 and the registers with their
// defaults. When the receiver stalls, the result register holds its value,
// the input register fills, and in_if.ready drops until the result moves.
module clap_switch_pwm_dimmer_top #(
  parameter int COUNTER_WIDTH = cspd_pkg::COUNTER_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  cspd_in_if.sink                        in_if,
  cspd_out_if.source                     out_if,
  input  logic                           cfg_we,
  input  logic [cspd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [cspd_pkg::CFG_W-1:0]     cfg_wdata
);

  cspd_pkg::cfg_t      cfg;
  cspd_pkg::step_in_t  stage_r;
  cspd_pkg::step_out_t result;
  cspd_pkg::step_out_t out_r;
  logic                stage_valid_r;
  logic                out_valid_r;
  logic                stage_go;
  logic                in_take;

  cspd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cspd_step #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (stage_go),
    .step_in  (stage_r),
    .cfg      (cfg),
    .step_out (result)
  );

  // Handshake: the staged step moves on when the result register frees up.
  assign stage_go    = stage_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !stage_valid_r || stage_go;
  assign in_take     = in_if.valid && in_if.ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      stage_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stage_r.tick          <= in_if.tick;
      stage_r.toggle_button <= in_if.toggle_button;
      stage_r.dim_button    <= in_if.dim_button;
      stage_r.clap          <= in_if.clap;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stage_go) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go) begin
      out_r <= result;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.lamp         = out_r.lamp;
  assign out_if.lamp_enabled = out_r.lamp_enabled;
  assign out_if.duty_level   = out_r.duty_level;

endmodule

@@ hdl/cspd_checker.sv @@
module cspd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       lamp,
  input logic       lamp_enabled,
  input logic [7:0] duty_level
);

  // A stalled result holds still until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(lamp) && $stable(lamp_enabled) &&
                                $stable(duty_level))
    else $error("result changed while stalled");

  // A lamp that is switched off is never driven.
  a_off_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !lamp_enabled |-> !lamp)
    else $error("lamp driven while disabled");

  // With the result side empty, the input side never backs up.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind clap_switch_pwm_dimmer_top cspd_checker u_cspd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .lamp         (out_if.lamp),
  .lamp_enabled (out_if.lamp_enabled),
  .duty_level   (out_if.duty_level)
);

@@ dv/tb_clap_switch_pwm_dimmer_top.sv @@
module tb_clap_switch_pwm_dimmer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cspd_pkg::*;

  localparam int CW = cspd_pkg::COUNTER_WIDTH;

  // Register indexes past the end of the map; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  localparam int RANDOM_PHASES    = 10;
  localparam int STEPS_PER_PHASE  = 85;
  localparam int MAX_WAIT         = 14;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  cspd_in_if  in_ch ();
  cspd_out_if out_ch ();

  clap_switch_pwm_dimmer_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // One row of the directed plan: either a register write or a polling step.
  typedef struct {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     val;
    step_in_t             stim;
    bit                   pinned;
    step_out_t            want;
  } plan_row_t;

  plan_row_t plan_q[$];
  step_out_t lamp_due_q[$];
  int        mismatches = 0;
  bit        send_lazy = 1'b1;
  bit        recv_lazy = 1'b1;

  // Shadow copy of the registers and of the controller state.
  cfg_t          regs_m;
  logic          lamp_q;
  logic          en_q;
  logic [CW-1:0] subtick_q;
  logic [CW-1:0] window_q;
  logic [CW-1:0] gap_q;
  logic [CW-1:0] pwm_q;
  logic [1:0]    claps_q;
  logic [7:0]    duty_q;
  logic          tog_latch_q;
  logic          dim_latch_q;

  function automatic void reset_lamp_model();
    regs_m.pwm_period        = RST_PWM_PERIOD;
    regs_m.duty_step         = RST_DUTY_STEP;
    regs_m.clap_min_gap      = RST_CLAP_MIN_GAP;
    regs_m.clap_window       = RST_CLAP_WINDOW;
    regs_m.window_unit_ticks = RST_WINDOW_UNIT_TICKS;
    lamp_q      = 1'b0;
    en_q        = 1'b0;
    subtick_q   = '0;
    window_q    = '0;
    gap_q       = '0;
    pwm_q       = '0;
    claps_q     = '0;
    duty_q      = RST_DUTY_REFERENCE;
    tog_latch_q = 1'b0;
    dim_latch_q = 1'b0;
  endfunction

  // Advances the shadow controller by one polling step and returns its outputs.
  function automatic step_out_t lamp_step(input step_in_t s);
    step_out_t r;
    // Counting comes first, and only on a tick.
    if (s.tick) begin
      subtick_q = subtick_q + 1'b1;
      gap_q     = gap_q + 1'b1;
      if (en_q) pwm_q = pwm_q + 1'b1;
    end
    // A fresh press of the toggle button flips the lamp.
    if (!s.toggle_button) begin
      if (!tog_latch_q) begin
        lamp_q      = ~lamp_q;
        tog_latch_q = 1'b1;
        if (lamp_q) begin
          pwm_q = '0;
          en_q  = 1'b1;
        end else begin
          en_q = 1'b0;
        end
      end
    end else begin
      tog_latch_q = 1'b0;
    end
    // Window unit rollover needs an exact match.
    if (subtick_q == regs_m.window_unit_ticks) begin
      subtick_q = '0;
      window_q  = window_q + 1'b1;
    end
    // Clap sequence: a valid clap counts, any other one restarts the sequence.
    if (s.clap) begin
      if (gap_q >= regs_m.clap_min_gap && window_q <= regs_m.clap_window) begin
        claps_q = claps_q + 2'd1;
        gap_q   = '0;
      end else begin
        window_q = '0;
        gap_q    = '0;
        claps_q  = '0;
      end
    end
    if (claps_q == CLAPS_TO_TOGGLE) begin
      lamp_q  = ~lamp_q;
      en_q    = lamp_q;
      claps_q = '0;
    end
    // A fresh press of the dim button lowers the duty reference or reloads it.
    if (!s.dim_button && !dim_latch_q) begin
      if (duty_q > regs_m.duty_step) duty_q = duty_q - regs_m.duty_step;
      else duty_q = regs_m.pwm_period;
      dim_latch_q = 1'b1;
    end else if (s.dim_button && dim_latch_q) begin
      dim_latch_q = 1'b0;
    end
    // PWM drive while the lamp is switched on.
    if (en_q) begin
      if (pwm_q >= regs_m.pwm_period) begin
        pwm_q  = '0;
        lamp_q = 1'b1;
      end else if (pwm_q > duty_q) begin
        lamp_q = 1'b0;
      end else begin
        lamp_q = 1'b1;
      end
    end
    r.lamp         = lamp_q;
    r.lamp_enabled = en_q;
    r.duty_level   = duty_q;
    return r;
  endfunction

  // Directed plan builders.
  function automatic void step_row(input logic t, tg, d, c);
    plan_row_t r;
    r.is_reg = 1'b0;
    r.idx    = '0;
    r.val    = '0;
    r.stim   = {t, tg, d, c};
    r.pinned = 1'b0;
    r.want   = '0;
    plan_q.push_back(r);
  endfunction

  function automatic void pinned_row(input logic t, tg, d, c, l, e, input logic [7:0] duty);
    plan_row_t r;
    r.is_reg = 1'b0;
    r.idx    = '0;
    r.val    = '0;
    r.stim   = {t, tg, d, c};
    r.pinned = 1'b1;
    r.want   = {l, e, duty};
    plan_q.push_back(r);
  endfunction

  function automatic void reg_row(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    plan_row_t r;
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    r.stim   = '0;
    r.pinned = 1'b0;
    r.want   = '0;
    plan_q.push_back(r);
  endfunction

  // Random polling step: mostly realistic button and clap activity, some noise.
  function automatic step_in_t draw_step();
    step_in_t s;
    if ($urandom_range(0, 5) == 0) begin
      s = step_in_t'(4'($urandom_range(0, 15)));
    end else begin
      s.tick          = ($urandom_range(0, 3) != 0);
      s.toggle_button = ($urandom_range(0, 11) != 0);
      s.dim_button    = ($urandom_range(0, 7) != 0);
      s.clap          = ($urandom_range(0, 4) == 0);
    end
    return s;
  endfunction

  // Register value for a random phase; the first two phases take the extremes.
  function automatic logic [CFG_W-1:0] pick_reg(input int ph);
    if (ph == 0) return '0;
    if (ph == 1) return '1;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 8'd1;
      3:       return CFG_W'($urandom_range(0, 255));
      default: return CFG_W'($urandom_range(2, 12));
    endcase
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Register write; the shadow registers follow.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PWM_PERIOD:        regs_m.pwm_period        = val;
      REG_DUTY_STEP:         regs_m.duty_step         = val;
      REG_CLAP_MIN_GAP:      regs_m.clap_min_gap      = val;
      REG_CLAP_WINDOW:       regs_m.clap_window       = val;
      REG_WINDOW_UNIT_TICKS: regs_m.window_unit_ticks = val;
      default: ;
    endcase
  endtask

  // Stops sending and waits until every step has produced its result.
  task automatic drain_steps();
    in_ch.valid <= 1'b0;
    while (lamp_due_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Sends one step, then records its expected outputs at the transfer.
  task automatic send_step(input step_in_t s, input bit pinned, input step_out_t want);
    int        gap;
    step_out_t predicted;
    gap = send_lazy ? $urandom_range(0, MAX_WAIT) : 0;
    if ($urandom_range(0, 19) == 0) send_lazy = !send_lazy;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.tick          <= s.tick;
    in_ch.toggle_button <= s.toggle_button;
    in_ch.dim_button    <= s.dim_button;
    in_ch.clap          <= s.clap;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = lamp_step(s);
    lamp_due_q.push_back(pinned ? want : predicted);
  endtask

  // Result side: random stalls, and a field-by-field check of each transfer.
  initial begin
    int        stall;
    step_out_t want;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = recv_lazy ? $urandom_range(0, MAX_WAIT) : 0;
      if ($urandom_range(0, 23) == 0) recv_lazy = !recv_lazy;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      if (lamp_due_q.size() == 0) begin
        $display("%0t: unexpected result lamp=%0b lamp_enabled=%0b duty_level=%0d",
                 $time, out_ch.lamp, out_ch.lamp_enabled, out_ch.duty_level);
        mismatches++;
      end else begin
        want = lamp_due_q.pop_front();
        if (out_ch.lamp !== want.lamp) begin
          $display("%0t: lamp expected %0b, actual %0b", $time, want.lamp, out_ch.lamp);
          mismatches++;
        end
        if (out_ch.lamp_enabled !== want.lamp_enabled) begin
          $display("%0t: lamp_enabled expected %0b, actual %0b",
                   $time, want.lamp_enabled, out_ch.lamp_enabled);
          mismatches++;
        end
        if (out_ch.duty_level !== want.duty_level) begin
          $display("%0t: duty_level expected %0d, actual %0d",
                   $time, want.duty_level, out_ch.duty_level);
          mismatches++;
        end
      end
    end
  end

  // Main sequence: reset, directed plan, random phases, drain.
  initial begin
    plan_row_t row;
    int        ph;
    int        k;
    reset_lamp_model();
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= '0;
    cfg_wdata           <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.tick          <= 1'b0;
    in_ch.toggle_button <= 1'b1;
    in_ch.dim_button    <= 1'b1;
    in_ch.clap          <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Dim presses walk the duty reference down and wrap it to the period.
    pinned_row(0, 1, 1, 0, 0, 0, 8'd50);
    pinned_row(0, 1, 0, 0, 0, 0, 8'd40);
    pinned_row(1, 1, 0, 0, 0, 0, 8'd40);
    pinned_row(0, 1, 1, 0, 0, 0, 8'd40);
    pinned_row(0, 1, 0, 0, 0, 0, 8'd30);
    pinned_row(0, 1, 1, 0, 0, 0, 8'd30);
    pinned_row(0, 1, 0, 0, 0, 0, 8'd20);
    pinned_row(0, 1, 1, 0, 0, 0, 8'd20);
    pinned_row(0, 1, 0, 0, 0, 0, 8'd10);
    pinned_row(0, 1, 1, 0, 0, 0, 8'd10);
    pinned_row(0, 1, 0, 0, 0, 0, 8'd50);
    // Toggle on, hold with a tick, release with an early clap, toggle off.
    pinned_row(0, 0, 1, 0, 1, 1, 8'd50);
    step_row(1, 0, 1, 0);
    step_row(1, 1, 1, 1);
    pinned_row(0, 0, 1, 0, 0, 0, 8'd50);
    // A double clap with no minimum gap turns the lamp on, and a zero period keeps it on.
    reg_row(REG_CLAP_MIN_GAP, 8'd0);
    reg_row(REG_PWM_PERIOD, 8'd0);
    step_row(0, 1, 1, 1);
    pinned_row(0, 1, 1, 1, 1, 1, 8'd50);
    pinned_row(1, 1, 1, 0, 1, 1, 8'd50);
    // Writes past the register map change nothing.
    reg_row(REG_UNUSED_LO, 8'h00);
    reg_row(REG_UNUSED_HI, 8'hFF);
    pinned_row(1, 1, 0, 0, 1, 1, 8'd40);
    // Registers at their extreme values, then all-ones and all-zeros steps.
    reg_row(REG_PWM_PERIOD, 8'hFF);
    reg_row(REG_DUTY_STEP, 8'hFF);
    reg_row(REG_CLAP_WINDOW, 8'h00);
    reg_row(REG_WINDOW_UNIT_TICKS, 8'h01);
    reg_row(REG_CLAP_MIN_GAP, 8'hFF);
    step_row(1, 1, 1, 1);
    step_row(1, 1, 0, 1);
    step_row(0, 0, 0, 0);
    step_row(1, 0, 1, 1);

    foreach (plan_q[i]) begin
      row = plan_q[i];
      if (row.is_reg) begin
        drain_steps();
        write_reg(row.idx, row.val);
      end else begin
        send_step(row.stim, row.pinned, row.want);
      end
    end

    // Random phases, each under its own register setting.
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_steps();
      write_reg(REG_PWM_PERIOD, pick_reg(ph));
      write_reg(REG_DUTY_STEP, pick_reg(ph));
      write_reg(REG_CLAP_MIN_GAP, pick_reg(ph));
      write_reg(REG_CLAP_WINDOW, pick_reg(ph));
      write_reg(REG_WINDOW_UNIT_TICKS, pick_reg(ph));
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI,
                  CFG_W'($urandom_range(0, 255)));
      for (k = 0; k < STEPS_PER_PHASE; k++) begin
        // Now and then the sender waits for every result to come back.
        if (k == STEPS_PER_PHASE / 2 && ph % 3 == 0) drain_steps();
        send_step(draw_step(), 1'b0, '0);
      end
    end

    in_ch.valid <= 1'b0;
    while (lamp_due_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
